FILE: src/jhs_pkg.sv
// shared widths, register codes and beat types of the jacobi stencil sweep
package jhs_pkg;

  localparam int unsigned ValW        = 32;
  localparam int unsigned SumW        = ValW + 2;
  localparam int unsigned RowW        = 12;
  localparam int unsigned ColW        = 6;
  localparam int unsigned GridWidthW  = 7;
  localparam int unsigned GridHeightW = 13;
  localparam int unsigned CfgW        = 13;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned MinDim      = 3;

  localparam logic [GridWidthW-1:0]  GridWidthRst  = GridWidthW'(64);
  localparam logic [GridHeightW-1:0] GridHeightRst = GridHeightW'(64);

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ValW-1:0] cell_value;
  } in_beat_t;

  typedef struct packed {
    logic [ValW-1:0] new_value;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
    logic            last_cell;
  } out_beat_t;

  // position of the arriving cell, seen by the datapath
  typedef struct packed {
    logic            emit;
    logic            last;
    logic            row_end;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
  } pos_info_t;

endpackage

FILE: src/jhs_in_if.sv
// input channel of the stencil sweep: one raster cell per beat
interface jhs_in_if
  import jhs_pkg::*;
();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/jhs_out_if.sv
// output channel of the stencil sweep: one updated interior cell per beat
interface jhs_out_if
  import jhs_pkg::*;
();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/jacobi_heat_stencil_sweep.sv
// top level of the jacobi four-point heat stencil sweep
// one cell is taken every clock while the result register is free or being drained; a result
// is registered when the cell below it is taken; the rate is set by the line buffer memory
// (MAX_WIDTH entries, one write and two registered reads per beat) and the four-input add in
// front of the result register; the line buffer is never cleared, border cells give no beat
module jacobi_heat_stencil_sweep
  import jhs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  jhs_in_if.sink             in_i,
  jhs_out_if.source          out_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic            in_ready, in_acc;
  logic [CW-1:0]   col;
  pos_info_t       info;
  logic [ValW-1:0] up, left, right;

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  jhs_pos_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos_ctr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (in_acc),
    .col_o       (col),
    .info_o      (info)
  );

  jhs_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .acc_i     (in_acc),
    .row_end_i (info.row_end),
    .col_i     (col),
    .cell_i    (in_i.data.cell_value),
    .up_o      (up),
    .left_o    (left),
    .right_o   (right)
  );

  jhs_stencil_out u_stencil_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .info_i     (info),
    .cell_i     (in_i.data.cell_value),
    .up_i       (up),
    .left_i     (left),
    .right_i    (right),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

  // a beat taken at an interior position must show up in the result register
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && info.emit |=> out_o.valid)
    else $error("interior cell taken but no result beat presented");

  // the row end always brings the column back to the first cell
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && info.row_end && !cfg_we_i |=> col == '0)
    else $error("column did not wrap at the row end");

  // the final interior cell is followed by the last cell of its row
  a_last_then_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && info.last && !cfg_we_i |=> info.row_end)
    else $error("final interior cell not followed by the row end");

endmodule

FILE: src/jhs_pos_ctr.sv
// grid size registers and raster row/column counters
module jhs_pos_ctr
  import jhs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               acc_i,
  output logic [CW-1:0]      col_o,
  output pos_info_t          info_o
);

  function automatic logic [CW-1:0] col_last_of(input logic [GridWidthW-1:0] v);
    int unsigned e;
    e = 32'(v);
    if (e < MinDim) begin
      e = MinDim;
    end else if (e > MAX_WIDTH) begin
      e = MAX_WIDTH;
    end
    return CW'(e - 1);
  endfunction

  function automatic logic [RW-1:0] row_last_of(input logic [GridHeightW-1:0] v);
    int unsigned e;
    e = 32'(v);
    if (e < MinDim) begin
      e = MinDim;
    end else if (e > MAX_HEIGHT) begin
      e = MAX_HEIGHT;
    end
    return RW'(e - 1);
  endfunction

  logic [CW-1:0] col_q, col_d, col_last_q, col_last_d;
  logic [RW-1:0] row_q, row_d, row_last_q, row_last_d;
  logic [RW-1:0] row_m1;
  logic          cfg_hit, row_end;

  assign row_end = (col_q == col_last_q);
  assign row_m1  = row_q - RW'(1);

  always_comb begin
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    cfg_hit    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH: begin
          col_last_d = col_last_of(cfg_wdata_i[GridWidthW-1:0]);
          cfg_hit    = 1'b1;
        end
        REG_GRID_HEIGHT: begin
          row_last_d = row_last_of(cfg_wdata_i[GridHeightW-1:0]);
          cfg_hit    = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      // any register write restarts the sweep
      col_d = '0;
      row_d = '0;
    end else if (acc_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = (row_q == row_last_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_last_q <= col_last_of(GridWidthRst);
      row_last_q <= row_last_of(GridHeightRst);
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
    end
  end

  assign col_o          = col_q;
  assign info_o.row_end = row_end;
  assign info_o.emit    = (row_q >= RW'(2)) && (col_q != '0) && !row_end;
  assign info_o.last    = info_o.emit && (row_q == row_last_q)
                          && (col_q == col_last_q - CW'(1));
  assign info_o.out_row = RowW'(row_m1);
  assign info_o.out_col = ColW'(col_q);

endmodule

FILE: src/jhs_line_buf.sv
// two-row line buffer memory with the stencil window registers
module jhs_line_buf
  import jhs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 64,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic            clk_i,
  input  logic            acc_i,
  input  logic            row_end_i,
  input  logic [CW-1:0]   col_i,
  input  logic [ValW-1:0] cell_i,
  output logic [ValW-1:0] up_o,
  output logic [ValW-1:0] left_o,
  output logic [ValW-1:0] right_o
);

  typedef struct packed {
    logic [ValW-1:0] upper;
    logic [ValW-1:0] middle;
  } lb_entry_t;

  lb_entry_t       mem [MAX_WIDTH];
  lb_entry_t       cur_q, nxt_q;
  logic [ValW-1:0] left_q;
  logic [CW:0]     ahead;
  logic [CW-1:0]   rd_addr;

  // next-but-one column is prefetched; at the row end the next row's first two columns
  assign ahead   = {1'b0, col_i} + (CW + 1)'(2);
  assign rd_addr = row_end_i ? CW'(1)
                 : ((ahead >= (CW + 1)'(MAX_WIDTH)) ? '0 : ahead[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mem[col_i] <= '{upper: cur_q.middle, middle: cell_i};
      left_q     <= cur_q.middle;
      nxt_q      <= mem[rd_addr];
      cur_q      <= row_end_i ? mem[CW'(0)] : nxt_q;
    end
  end

  assign up_o    = cur_q.upper;
  assign left_o  = left_q;
  assign right_o = nxt_q.middle;

endmodule

FILE: src/jhs_stencil_out.sv
// four-point sum, quarter scaling and the result register
module jhs_stencil_out
  import jhs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  pos_info_t       info_i,
  input  logic [ValW-1:0] cell_i,
  input  logic [ValW-1:0] up_i,
  input  logic [ValW-1:0] left_i,
  input  logic [ValW-1:0] right_i,
  output logic            in_ready_o,
  jhs_out_if.source       out_o
);

  logic            valid_q, valid_d;
  out_beat_t       beat_q;
  logic [SumW-1:0] sum;

  assign sum = SumW'(up_i) + SumW'(cell_i) + SumW'(left_i) + SumW'(right_i);

  assign in_ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (acc_i && info_i.emit) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && info_i.emit) begin
      beat_q.new_value <= sum[SumW-1:2];
      beat_q.out_row   <= info_i.out_row;
      beat_q.out_col   <= info_i.out_col;
      beat_q.last_cell <= info_i.last;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = beat_q;

endmodule

FILE: tb/sv/jacobi_heat_stencil_sweep_tb.sv
// testbench of the jacobi heat stencil sweep: directed grids, clamped sizes and random sweeps
module jacobi_heat_stencil_sweep_tb;
  import jhs_pkg::*;

  localparam int unsigned MaxWidth    = 64;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned IdlePct     = 27;
  localparam int unsigned RandomCells = 220;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  jhs_in_if  cell_if ();
  jhs_out_if upd_if ();

  jacobi_heat_stencil_sweep #(
    .MAX_WIDTH  (MaxWidth),
    .MAX_HEIGHT (MaxHeight)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cell_if),
    .out_o       (upd_if)
  );

  // own copy of the sweep state
  logic [ValW-1:0]        upper_line [MaxWidth];
  logic [ValW-1:0]        middle_line [MaxWidth];
  int unsigned            cur_row;
  int unsigned            cur_col;
  logic [GridWidthW-1:0]  width_reg;
  logic [GridHeightW-1:0] height_reg;
  out_beat_t              updates_due [$];
  bit                     mismatch_seen;
  bit                     steady;
  int unsigned            cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    upd_if.ready = steady || ($urandom_range(99) >= IdlePct);
  end

  function automatic int unsigned grid_cols();
    if (width_reg < MinDim) return MinDim;
    if (width_reg > MaxWidth) return MaxWidth;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned grid_rows();
    if (height_reg < MinDim) return MinDim;
    if (height_reg > MaxHeight) return MaxHeight;
    return 32'(height_reg);
  endfunction

  // take one raster cell; queue the interior update that the cell completes, if any
  function automatic void advance_sweep(logic [ValW-1:0] cell_val);
    int unsigned     w;
    int unsigned     h;
    int unsigned     r;
    int unsigned     c;
    logic [SumW-1:0] total;
    out_beat_t       upd;
    w = grid_cols();
    h = grid_rows();
    r = cur_row;
    c = cur_col;
    if (r >= 2 && c >= 1 && c + 1 < w) begin
      // up and left still sit in the upper line, right in the middle line
      total = SumW'(upper_line[c]) + SumW'(cell_val) + SumW'(upper_line[c-1])
            + SumW'(middle_line[c+1]);
      upd.new_value = total[SumW-1:2];
      upd.out_row   = RowW'(r - 1);
      upd.out_col   = ColW'(c);
      upd.last_cell = (r - 1 == h - 2) && (c == w - 2);
      updates_due.push_back(upd);
    end
    upper_line[c]  = middle_line[c];
    middle_line[c] = cell_val;
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && upd_if.valid && upd_if.ready) begin
      if (updates_due.size() == 0) begin
        $display("%0t: unexpected update beat, expected none, actual %p", $time, upd_if.data);
        mismatch_seen = 1'b1;
      end else begin
        want = updates_due.pop_front();
        check_field("new_value", want.new_value, upd_if.data.new_value);
        check_field("out_row", want.out_row, upd_if.data.out_row);
        check_field("out_col", want.out_col, upd_if.data.out_col);
        check_field("last_cell", want.last_cell, upd_if.data.last_cell);
      end
    end
  end

  function automatic logic [ValW-1:0] pick_cell();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '1;
    if (roll < 20) return '0;
    return $urandom();
  endfunction

  task automatic send_cell(input logic [ValW-1:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IdlePct) begin
      cell_if.valid = 1'b0;
      cell_if.data.cell_value = $urandom();
      @(negedge clk);
    end
    cell_if.valid = 1'b1;
    cell_if.data.cell_value = value;
    do @(posedge clk); while (!cell_if.ready);
    advance_sweep(value);
  endtask

  task automatic send_cells(input int unsigned count);
    repeat (count) send_cell(pick_cell());
  endtask

  // stop sending and let every expected update come out
  task automatic wait_idle();
    @(negedge clk);
    cell_if.valid = 1'b0;
    while (updates_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // any register write restarts the sweep at the top left corner
  task automatic write_grid_reg(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_GRID_WIDTH:  width_reg  = value[GridWidthW-1:0];
      REG_GRID_HEIGHT: height_reg = value[GridHeightW-1:0];
      default: ;
    endcase
    cur_row = 0;
    cur_col = 0;
  endtask

  // reset size 64 by 64, only a few cells into the third row; the next write cuts it short
  task automatic test_reset_dims();
    send_cells(2 * grid_cols() + 8);
  endtask

  task automatic test_saturated_sum();
    write_grid_reg(REG_GRID_WIDTH, CfgW'(3));
    write_grid_reg(REG_GRID_HEIGHT, CfgW'(3));
    repeat (9) send_cell('1);
  endtask

  // second sweep straight after the wrap; the neighbours carry into bit 32
  task automatic test_wrap_carry();
    logic [ValW-1:0] grid [9];
    grid = '{32'h0, 32'h1, 32'h0, 32'h2, 32'hDEADBEEF, 32'h3, 32'h0, 32'hFFFFFFFC, 32'h0};
    foreach (grid[i]) send_cell(grid[i]);
  endtask

  task automatic test_low_clamp();
    write_grid_reg(REG_GRID_WIDTH, CfgW'(0));
    write_grid_reg(REG_GRID_HEIGHT, CfgW'(2));
    send_cells(9);
  endtask

  task automatic test_wide_clamp();
    write_grid_reg(REG_GRID_WIDTH, CfgW'(127));
    write_grid_reg(REG_GRID_HEIGHT, CfgW'(3));
    send_cells(grid_cols() * grid_rows());
  endtask

  // narrowest grid at the tallest clamped height, first rows only
  task automatic test_tall_clamp();
    write_grid_reg(REG_GRID_WIDTH, CfgW'(3));
    write_grid_reg(REG_GRID_HEIGHT, CfgW'(8191));
    send_cells(10 * grid_cols());
  endtask

  task automatic test_random_sweeps();
    int unsigned sent;
    int unsigned roll;
    int unsigned area;
    int unsigned count;
    logic [CfgW-1:0] w_val;
    logic [CfgW-1:0] h_val;
    sent = 0;
    steady = 1'b1;
    while (sent < RandomCells) begin
      if (sent >= RandomCells / 4) steady = 1'b0;
      roll = $urandom_range(99);
      if (roll < 70) w_val = CfgW'($urandom_range(3, 10));
      else if (roll < 80) w_val = CfgW'(64);
      else if (roll < 90) w_val = CfgW'($urandom_range(0, 2));
      else w_val = CfgW'($urandom_range(11, 127));
      roll = $urandom_range(99);
      if (roll < 70) h_val = CfgW'($urandom_range(3, 8));
      else if (roll < 80) h_val = CfgW'($urandom_range(0, 2));
      else if (roll < 88) h_val = CfgW'($urandom_range(9, 40));
      else if (roll < 94) h_val = CfgW'(4096);
      else h_val = CfgW'(8191);
      case ($urandom_range(2))
        0: write_grid_reg(REG_GRID_WIDTH, w_val);
        1: write_grid_reg(REG_GRID_HEIGHT, h_val);
        default: begin
          write_grid_reg(REG_GRID_HEIGHT, h_val);
          write_grid_reg(REG_GRID_WIDTH, w_val);
        end
      endcase
      area = grid_cols() * grid_rows();
      // whole sweeps and a partial tail on small grids, a few rows on big ones
      if (area <= 200) count = area * $urandom_range(1, 2) + $urandom_range(area - 1);
      else count = $urandom_range(3 * grid_cols(), 200);
      if (count > RandomCells - sent) count = RandomCells - sent;
      send_cells(count);
      sent += count;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = REG_GRID_WIDTH;
    cfg_wdata               = '0;
    cell_if.valid           = 1'b0;
    cell_if.data.cell_value = '0;
    upd_if.ready            = 1'b0;
    steady                  = 1'b0;
    mismatch_seen           = 1'b0;
    cycles                  = 0;
    cur_row                 = 0;
    cur_col                 = 0;
    width_reg               = GridWidthRst;
    height_reg              = GridHeightRst;
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_dims();
    test_saturated_sum();
    test_wrap_carry();
    test_low_clamp();
    test_wide_clamp();
    test_tall_clamp();
    test_random_sweeps();

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (!mismatch_seen) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/jhs_pkg.sv
src/jhs_in_if.sv
src/jhs_out_if.sv
src/jhs_pos_ctr.sv
src/jhs_line_buf.sv
src/jhs_stencil_out.sv
src/jacobi_heat_stencil_sweep.sv
tb/sv/jacobi_heat_stencil_sweep_tb.sv
